[sv/mrrl_pkg.sv]
// ----------------------------------------------------------------------------
// Motion report rate limiter package
// Shared types, axis and command codes, constants and a saturating adder.
// ----------------------------------------------------------------------------
package mrrl_pkg;

  localparam logic [15:0] AXIS_X = 16'd0;
  localparam logic [15:0] AXIS_Y = 16'd1;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd10;
  localparam logic [15:0] MS_MAX         = 16'hFFFF;

  // One emitted result
  typedef struct packed {
    logic [15:0]        code;
    logic signed [31:0] value;
    logic               sync;
    logic               last;
  } res_t;

  // One accepted input item
  typedef struct packed {
    logic               cmd;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic               sync;
  } item_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [31:0] s;
    begin
      s = a + b;
      if (a[31] == b[31] && s[31] != a[31]) begin
        sat_add = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        sat_add = s;
      end
    end
  endfunction

endpackage

[sv/motion_report_rate_limiter_unit.sv]
// ----------------------------------------------------------------------------
// Motion report rate limiter unit
// Coalesces X/Y motion deltas into saturating sums and emits them no more
// often than the programmed interval; other event codes pass through.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | in_valid/in_stall   | cmd, event_code, event_value,
//           |           |                     | event_sync
//  output   | out       | out_valid/out_stall | out_code, out_value, out_sync,
//           |           |                     | last_of_run
//  config   | in        | cfg_we              | cfg_wdata (interval_ms)
//
// An item is held in the input register; its results then pass through the
// result queue to the output. Items that give zero or one result go through
// at one per cycle while the output does not stall. A flush with both axes
// fills both slots of the two-entry result queue and the output port then
// sets the pace. Reset (rst, synchronous) empties both registers, clears the
// state and loads interval 10. An output stall holds the queue, and the input
// stalls once the queue has no room for the results of the held item.
// ----------------------------------------------------------------------------
module motion_report_rate_limiter_unit
  import mrrl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [15:0]        event_code,
  input  logic signed [31:0] event_value,
  input  logic               event_sync,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_code,
  output logic signed [31:0] out_value,
  output logic               out_sync,
  output logic               last_of_run
);

  logic [15:0]        interval_ms;
  logic signed [31:0] sum_x, sum_y;
  logic               x_present, y_present;
  logic [15:0]        ms_since_report;
  logic               reported_once;
  logic               flush_pending;

  item_t              item;
  logic               item_valid;

  res_t               q [2];
  logic [1:0]         cnt;

  // next-state values
  logic signed [31:0] sum_x_next, sum_y_next;
  logic               x_present_next, y_present_next;
  logic [15:0]        ms_since_report_next;
  logic               reported_once_next;
  logic               flush_pending_next;

  logic               is_axis, flush;
  logic               x_sel, y_sel;
  logic [1:0]         n_res;
  res_t               r0, r1;
  logic               pop, proc;
  logic [1:0]         base;
  logic [2:0]         need;

  // --------------------------------------------------------------------------
  // Item evaluation
  // --------------------------------------------------------------------------
  always_comb begin
    sum_x_next           = sum_x;
    sum_y_next           = sum_y;
    x_present_next       = x_present;
    y_present_next       = y_present;
    ms_since_report_next = ms_since_report;
    reported_once_next   = reported_once;
    flush_pending_next   = flush_pending;
    flush                = 1'b0;
    r0                   = '0;
    r1                   = '0;
    n_res                = 2'd0;
    x_sel                = 1'b0;
    y_sel                = 1'b0;
    is_axis              = (item.code == AXIS_X) || (item.code == AXIS_Y);

    if (item.cmd == CMD_TICK) begin
      if (ms_since_report != MS_MAX) begin
        ms_since_report_next = ms_since_report + 16'd1;
      end
      flush = flush_pending && (ms_since_report_next >= interval_ms);
    end else if (!is_axis) begin
      r0    = '{code: item.code, value: item.value, sync: item.sync, last: 1'b1};
      n_res = 2'd1;
    end else begin
      if (item.code == AXIS_X) begin
        sum_x_next     = sat_add(sum_x, item.value);
        x_present_next = 1'b1;
      end else begin
        sum_y_next     = sat_add(sum_y, item.value);
        y_present_next = 1'b1;
      end
      if (item.sync) begin
        if (!reported_once || ms_since_report >= interval_ms) begin
          flush = 1'b1;
        end else begin
          flush_pending_next = 1'b1;
        end
      end
    end

    if (flush) begin
      x_sel = x_present_next;
      y_sel = y_present_next;
      if (x_sel) begin
        r0 = '{code: AXIS_X, value: sum_x_next, sync: !y_sel, last: !y_sel};
        r1 = '{code: AXIS_Y, value: sum_y_next, sync: 1'b1, last: 1'b1};
      end else begin
        r0 = '{code: AXIS_Y, value: sum_y_next, sync: 1'b1, last: 1'b1};
      end
      n_res                = {1'b0, x_sel} + {1'b0, y_sel};
      sum_x_next           = '0;
      sum_y_next           = '0;
      x_present_next       = 1'b0;
      y_present_next       = 1'b0;
      ms_since_report_next = '0;
      reported_once_next   = 1'b1;
      flush_pending_next   = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign base      = cnt - {1'b0, pop};
  assign need      = {1'b0, base} + {1'b0, n_res};
  assign proc      = item_valid && (need <= 3'd2);
  assign in_stall  = item_valid && !proc;

  assign out_code    = q[0].code;
  assign out_value   = q[0].value;
  assign out_sync    = q[0].sync;
  assign last_of_run = q[0].last;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms     <= INTERVAL_RESET;
      sum_x           <= '0;
      sum_y           <= '0;
      x_present       <= 1'b0;
      y_present       <= 1'b0;
      ms_since_report <= '0;
      reported_once   <= 1'b0;
      flush_pending   <= 1'b0;
      item_valid      <= 1'b0;
      cnt             <= 2'd0;
    end else begin
      if (cfg_we) begin
        interval_ms <= cfg_wdata;
      end
      if (proc) begin
        sum_x           <= sum_x_next;
        sum_y           <= sum_y_next;
        x_present       <= x_present_next;
        y_present       <= y_present_next;
        ms_since_report <= ms_since_report_next;
        reported_once   <= reported_once_next;
        flush_pending   <= flush_pending_next;
        cnt             <= need[1:0];
      end else begin
        cnt <= base;
      end
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (proc) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Payload: input register and result queue
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{cmd: cmd, code: event_code, value: event_value, sync: event_sync};
    end
    // write new results behind what remains after the advance
    if (proc && n_res != 2'd0 && base == 2'd0) begin
      q[0] <= r0;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (proc && n_res == 2'd2) begin
      q[1] <= r1;
    end else if (proc && n_res == 2'd1 && base == 2'd1) begin
      q[1] <= r0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_range : assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");

  a_pending_after_report : assert property (@(posedge clk) disable iff (rst)
    flush_pending |-> reported_once)
    else $error("flush pending before any report");

  a_flush_clears : assert property (@(posedge clk) disable iff (rst)
    proc && flush |=> !x_present && !y_present && ms_since_report == 16'd0
                      && !flush_pending)
    else $error("flush did not clear the accumulator state");

  a_full_queue_last : assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> q[1].last)
    else $error("queue tail does not close a run");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion report rate limiter testbench
// Drives motion events and millisecond ticks through the rate limiter. Each
// transfer is checked against a typed row's results or a model of coalescing
// and report pacing. A short table of directed rows runs first, then random
// traffic under several interval settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb
  import mrrl_pkg::*;
;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 6;
  localparam int SETTLE       = 4;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam res_t  NO_RES = '0;
  localparam item_t TICK   = '{CMD_TICK, 16'd0, 32'sd0, 1'b0};

  typedef enum logic [1:0] {ROW_ITEM, ROW_TICKS, ROW_CFG} row_kind_t;

  // arg holds the tick count or the interval; typed rows carry their own results
  typedef struct packed {
    row_kind_t  kind;
    logic [16:0] arg;
    item_t      it;
    logic       typed;
    logic [1:0] nres;
    res_t       r0;
    res_t       r1;
  } row_t;

  localparam int NUM_ROWS = 25;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, 16'd2, S_MIN, 1'b1}, 1'b1, 2'd1,
      '{16'd2, S_MIN, 1'b1, 1'b1}, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, 16'hFFFF, S_MAX, 1'b0}, 1'b1, 2'd1,
      '{16'hFFFF, S_MAX, 1'b0, 1'b1}, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, 32'sd5, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    // first report goes out at once
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, -32'sd3, 1'b1}, 1'b1, 2'd1,
      '{AXIS_X, 32'sd2, 1'b1, 1'b1}, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, 32'sd9, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, 32'sd1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_TICKS, 17'd9, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, TICK, 1'b1, 2'd1, '{AXIS_Y, 32'sd10, 1'b1, 1'b1}, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, S_MAX, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, 32'sd1, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, S_MIN, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, -32'sd1, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_TICKS, 17'd10, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, 32'sd0, 1'b1}, 1'b1, 2'd2,
      '{AXIS_X, S_MAX, 1'b0, 1'b0}, '{AXIS_Y, S_MIN, 1'b1, 1'b1}},
    '{ROW_CFG, 17'd0, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, 32'sd4, 1'b1}, 1'b1, 2'd1,
      '{AXIS_Y, 32'sd4, 1'b1, 1'b1}, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, -32'sd1, 1'b1}, 1'b1, 2'd1,
      '{AXIS_X, -32'sd1, 1'b1, 1'b1}, NO_RES},
    '{ROW_CFG, 17'h0FFFF, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, 32'sd3, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, 16'h7FFE, 32'sd1, 1'b0}, 1'b1, 2'd1,
      '{16'h7FFE, 32'sd1, 1'b0, 1'b1}, NO_RES},
    '{ROW_CFG, 17'd0, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    // immediate flush cancels the deferred one
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_Y, 32'sd2, 1'b1}, 1'b1, 2'd2,
      '{AXIS_X, 32'sd3, 1'b0, 1'b0}, '{AXIS_Y, 32'sd2, 1'b1, 1'b1}},
    '{ROW_ITEM, 17'd0, TICK, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, 17'h0FFFF, TICK, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_ITEM, 17'd0, '{CMD_EVENT, AXIS_X, 32'sd3, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES}
  };

  logic               clk;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [15:0]        cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               cmd         = CMD_EVENT;
  logic [15:0]        event_code  = '0;
  logic signed [31:0] event_value = '0;
  logic               event_sync  = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [15:0]        out_code;
  logic signed [31:0] out_value;
  logic               out_sync;
  logic               last_of_run;

  // model of the block
  logic [15:0]        gap_ms       = INTERVAL_RESET;
  logic signed [31:0] acc_x        = '0;
  logic signed [31:0] acc_y        = '0;
  logic               have_x       = 1'b0;
  logic               have_y       = 1'b0;
  logic [15:0]        ms_elapsed   = '0;
  logic               flushed_once = 1'b0;
  logic               deferred     = 1'b0;

  res_t due_reports [$];
  res_t head;
  int   mismatches  = 0;
  int   cycle_count = 0;
  bit   calm        = 1'b0;

  motion_report_rate_limiter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .event_code (event_code),
    .event_value(event_value),
    .event_sync (event_sync),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_code   (out_code),
    .out_value  (out_value),
    .out_sync   (out_sync),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = a + b;
    if (s[32] != s[31]) begin
      return s[32] ? S_MIN : S_MAX;
    end
    return s[31:0];
  endfunction

  function automatic int flush_sums(output res_t emit [2]);
    int n;
    n = 0;
    emit[0] = '0;
    emit[1] = '0;
    if (have_x) begin
      emit[n] = '{AXIS_X, acc_x, !have_y, 1'b0};
      n++;
    end
    if (have_y) begin
      emit[n] = '{AXIS_Y, acc_y, 1'b1, 1'b0};
      n++;
    end
    if (n > 0) begin
      emit[n-1].last = 1'b1;
    end
    acc_x        = '0;
    acc_y        = '0;
    have_x       = 1'b0;
    have_y       = 1'b0;
    ms_elapsed   = '0;
    flushed_once = 1'b1;
    deferred     = 1'b0;
    return n;
  endfunction

  function automatic int coalesce_item(input item_t it, output res_t emit [2]);
    emit[0] = '0;
    emit[1] = '0;
    if (it.cmd == CMD_TICK) begin
      if (ms_elapsed != MS_MAX) begin
        ms_elapsed++;
      end
      if (deferred && ms_elapsed >= gap_ms) begin
        return flush_sums(emit);
      end
      return 0;
    end
    if (it.code != AXIS_X && it.code != AXIS_Y) begin
      emit[0] = '{it.code, it.value, it.sync, 1'b1};
      return 1;
    end
    if (it.code == AXIS_X) begin
      acc_x  = clamp_add(acc_x, it.value);
      have_x = 1'b1;
    end else begin
      acc_y  = clamp_add(acc_y, it.value);
      have_y = 1'b1;
    end
    if (!it.sync) begin
      return 0;
    end
    if (!flushed_once || ms_elapsed >= gap_ms) begin
      return flush_sums(emit);
    end
    deferred = 1'b1;
    return 0;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick     = $urandom_range(99);
    it.cmd   = CMD_EVENT;
    it.code  = 16'($urandom);
    it.value = $urandom;
    it.sync  = 1'($urandom_range(1));
    if (pick < 30) begin
      it.cmd = CMD_TICK;  // other fields stay random and must be ignored
    end else if (pick < 45) begin
      it.code = 16'($urandom_range(65535, 2));
    end else begin
      it.code = $urandom_range(1) ? AXIS_Y : AXIS_X;
      case ($urandom_range(9))
        0:       it.value = $urandom;
        1:       it.value = $urandom_range(1) ? S_MAX : S_MIN;
        default: it.value = int'($urandom_range(200)) - 100;
      endcase
      it.sync = ($urandom_range(99) < 35);
    end
    return it;
  endfunction

  // Hold the payload until the transfer, then occasionally idle before the next item.
  task automatic send_item(input item_t it, input logic typed, input logic [1:0] nres,
                           input res_t r0, input res_t r1);
    res_t emit [2];
    int   n;
    in_valid    <= 1'b1;
    cmd         <= it.cmd;
    event_code  <= it.code;
    event_value <= it.value;
    event_sync  <= it.sync;
    do @(posedge clk); while (in_stall);
    n = coalesce_item(it, emit);
    if (typed) begin
      if (nres > 0) due_reports.push_back(r0);
      if (nres > 1) due_reports.push_back(r1);
    end else begin
      for (int k = 0; k < n; k++) due_reports.push_back(emit[k]);
    end
    if (!calm && $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Let every expected result arrive, then allow for items still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_ms     = v;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("motion_report_rate_limiter_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("unexpected transfer: code %0d value %0d", out_code, out_value);
        mismatches++;
      end else begin
        head = due_reports.pop_front();
        if (out_code !== head.code) begin
          $error("out_code: expected %0d, got %0d", head.code, out_code);
          mismatches++;
        end
        if (out_value !== head.value) begin
          $error("out_value: expected %0d, got %0d", head.value, out_value);
          mismatches++;
        end
        if (out_sync !== head.sync) begin
          $error("out_sync: expected %0d, got %0d", head.sync, out_sync);
          mismatches++;
        end
        if (last_of_run !== head.last) begin
          $error("last_of_run: expected %0d, got %0d", head.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t        row;
    logic [15:0] phase_gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_CFG:   write_interval(row.arg[15:0]);
        ROW_TICKS: repeat (row.arg) send_item(TICK, 1'b0, 2'd0, NO_RES, NO_RES);
        default:   send_item(row.it, row.typed, row.nres, row.r0, row.r1);
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_gap = 16'd3;
        1:       phase_gap = 16'd0;
        2:       phase_gap = 16'($urandom_range(8, 1));
        3:       phase_gap = 16'hFFFF;
        4:       phase_gap = 16'($urandom_range(20, 2));
        default: phase_gap = 16'd1;
      endcase
      write_interval(phase_gap);
      calm = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(149) == 0) begin
          wait_drained();
        end
        send_item(random_item(), 1'b0, 2'd0, NO_RES, NO_RES);
      end
    end
    calm = 1'b0;

    wait_drained();
    if (mismatches == 0) begin
      $display("motion_report_rate_limiter_unit verification clean");
    end else begin
      $display("motion_report_rate_limiter_unit verification failed");
    end
    $finish;
  end

endmodule
